// ===== hw/rtl/timer_queue_with_rearm_unit_assert.svh =====
// Assertion macros shared by the timer queue RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef TIMER_QUEUE_WITH_REARM_UNIT_ASSERT_SVH
`define TIMER_QUEUE_WITH_REARM_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define TQR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TQR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TQR_ASSERT_IMP(label, ante, cons, msg)
`define TQR_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/tqr_pkg.sv =====
// Shared types and constants of the timer queue.
// No dependencies; used by tqr_ctrl, tqr_dp and the top level.
package tqr_pkg;

  localparam int EXP_W = 63;
  localparam int IV_W = 40;
  localparam int GEN_W = 8;
  localparam int SLOT_W = 5;
  localparam int MAX_RES = 32;
  localparam int RES_IW = 5;
  localparam int RES_CW = 6;

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  localparam logic [2:0] KIND_ADDED = 3'd0;
  localparam logic [2:0] KIND_FULL = 3'd1;
  localparam logic [2:0] KIND_CANCELLED = 3'd2;
  localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
  localparam logic [2:0] KIND_EXPIRED = 3'd4;
  localparam logic [2:0] KIND_NONE = 3'd5;

  typedef struct packed {
    logic latch;
    logic scan_start;
    logic cancel_chk;
    logic add_do;
    logic apply;
    logic emit_rd;
    logic emit_out;
    logic out_single;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic is_add;
    logic is_cancel;
    logic pick_ok;
    logic any_res;
    logic emit_last;
  } sts_t;

endpackage

// ===== hw/rtl/tqr_ctrl.sv =====
// Sequencer of the timer queue: decodes a command and steps the datapath.
// Depends on tqr_pkg.
module tqr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       command,
  input  tqr_pkg::sts_t    sts,
  output tqr_pkg::cmd_t    cmd,
  output logic             busy
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_CHECK    = 8'b0000_0010,
    S_SCAN     = 8'b0000_0100,
    S_APPLY    = 8'b0000_1000,
    S_ADD      = 8'b0001_0000,
    S_SINGLE   = 8'b0010_0000,
    S_EMIT_RD  = 8'b0100_0000,
    S_EMIT_OUT = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          if (command == tqr_pkg::CMD_CANCEL) begin
            state_next = S_CHECK;
          end else begin
            cmd.scan_start = 1'b1;
            state_next = S_SCAN;
          end
        end
      end
      S_CHECK: begin
        cmd.cancel_chk = 1'b1;
        cmd.scan_start = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          if (sts.is_add) state_next = S_ADD;
          else if (sts.is_cancel) state_next = S_SINGLE;
          else if (sts.pick_ok) state_next = S_APPLY;
          else if (sts.any_res) state_next = S_EMIT_RD;
          else state_next = S_SINGLE;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        cmd.scan_start = 1'b1;
        state_next = S_SCAN;
      end
      S_ADD: begin
        cmd.add_do = 1'b1;
        state_next = S_IDLE;
      end
      S_SINGLE: begin
        cmd.out_single = 1'b1;
        state_next = S_IDLE;
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        cmd.emit_out = 1'b1;
        state_next = sts.emit_last ? S_IDLE : S_EMIT_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== hw/rtl/tqr_dp.sv =====
// Datapath of the timer queue: slot tables, scan unit, result buffer, outputs.
// Depends on tqr_pkg and timer_queue_with_rearm_unit_assert.svh.
`include "timer_queue_with_rearm_unit_assert.svh"
module tqr_dp #(
  parameter int TIMER_SLOTS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tqr_pkg::cmd_t                 cmd,
  output tqr_pkg::sts_t                 sts,
  input  logic [1:0]                    command,
  input  logic [tqr_pkg::EXP_W-1:0]     expiry_time,
  input  logic [tqr_pkg::IV_W-1:0]      repeat_interval,
  input  logic [tqr_pkg::EXP_W-1:0]     now_time,
  input  logic [tqr_pkg::SLOT_W-1:0]    cancel_slot,
  input  logic [tqr_pkg::GEN_W-1:0]     cancel_generation,
  output logic                          valid,
  output logic [2:0]                    kind,
  output logic [tqr_pkg::SLOT_W-1:0]    handle_slot,
  output logic [tqr_pkg::GEN_W-1:0]     handle_generation,
  output logic                          was_rearmed,
  output logic                          earliest_changed,
  output logic [tqr_pkg::EXP_W-1:0]     next_deadline,
  output logic                          deadline_valid,
  output logic                          last
);

  localparam int IW = $clog2(TIMER_SLOTS);
  localparam int XW = (IW > tqr_pkg::SLOT_W) ? IW + 1 : tqr_pkg::SLOT_W + 1;
  localparam int BW = IW + tqr_pkg::GEN_W + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TIMER_SLOTS - 1);

  // Latched item.
  logic [1:0]                 r_cmd;
  logic [tqr_pkg::EXP_W-1:0]  r_exp;
  logic [tqr_pkg::IV_W-1:0]   r_iv;
  logic [tqr_pkg::EXP_W-1:0]  r_now;
  logic [tqr_pkg::SLOT_W-1:0] r_cs;
  logic [tqr_pkg::GEN_W-1:0]  r_cg;

  // Slot state.
  logic [tqr_pkg::EXP_W-1:0]  mem_exp [TIMER_SLOTS];
  logic [tqr_pkg::IV_W-1:0]   mem_iv [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0]     live;
  logic [TIMER_SLOTS-1:0]     taken;
  logic [tqr_pkg::GEN_W-1:0]  gen [TIMER_SLOTS];

  // Scan unit.
  logic                       scan_on;
  logic [IW-1:0]              sidx;
  logic                       rd_v;
  logic [IW-1:0]              rd_idx;
  logic [tqr_pkg::EXP_W-1:0]  rd_exp;
  logic [tqr_pkg::IV_W-1:0]   rd_iv;
  logic                       done_q;
  logic                       any_live;
  logic [tqr_pkg::EXP_W-1:0]  best;
  logic                       free_found;
  logic [IW-1:0]              free_slot;
  logic                       pick_found;
  logic [IW-1:0]              pick_slot;
  logic [tqr_pkg::EXP_W-1:0]  pick_exp;
  logic [tqr_pkg::IV_W-1:0]   pick_iv;

  // Result buffer for timeouts.
  logic [BW-1:0]              bmem [tqr_pkg::MAX_RES];
  logic [BW-1:0]              b_rd;
  logic [tqr_pkg::RES_CW-1:0] n;
  logic [tqr_pkg::RES_IW-1:0] eidx;

  logic                       c_hit;
  logic                       hit_now;
  logic [XW-1:0]              cs_ext;
  logic [IW-1:0]              cs_idx;
  logic [tqr_pkg::EXP_W:0]    rearm_sum;
  logic [tqr_pkg::EXP_W-1:0]  rearm_exp;
  logic                       add_early;
  logic                       we_exp;
  logic [IW-1:0]              w_addr;
  logic [tqr_pkg::EXP_W-1:0]  w_exp;

  assign cs_ext = XW'(r_cs);
  assign cs_idx = cs_ext[IW-1:0];
  assign hit_now = (cs_ext < XW'(TIMER_SLOTS)) && live[cs_idx] && (gen[cs_idx] == r_cg);

  assign rearm_sum = {1'b0, r_now} + (tqr_pkg::EXP_W + 1)'(pick_iv);
  assign rearm_exp = rearm_sum[tqr_pkg::EXP_W] ? '1 : rearm_sum[tqr_pkg::EXP_W-1:0];
  assign add_early = !any_live || (r_exp < best);

  always_comb begin
    we_exp = 1'b0;
    w_addr = free_slot;
    w_exp = r_exp;
    if (cmd.add_do && free_found) begin
      we_exp = 1'b1;
    end else if (cmd.apply && (pick_iv != '0)) begin
      we_exp = 1'b1;
      w_addr = pick_slot;
      w_exp = rearm_exp;
    end
  end

  // Expiry and interval tables: one write, one registered read port.
  always_ff @(posedge clk) begin
    if (we_exp) mem_exp[w_addr] <= w_exp;
    if (cmd.add_do && free_found) mem_iv[free_slot] <= r_iv;
    rd_exp <= mem_exp[sidx];
    rd_iv <= mem_iv[sidx];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      r_cmd <= command;
      r_exp <= expiry_time;
      r_iv <= repeat_interval;
      r_now <= now_time;
      r_cs <= cancel_slot;
      r_cg <= cancel_generation;
    end
    if (cmd.cancel_chk) c_hit <= hit_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
      taken <= '0;
      for (int i = 0; i < TIMER_SLOTS; i++) gen[i] <= '0;
    end else begin
      if (cmd.latch) taken <= '0;
      if (cmd.cancel_chk && hit_now) begin
        live[cs_idx] <= 1'b0;
        gen[cs_idx] <= gen[cs_idx] + 1'b1;
      end
      if (cmd.add_do && free_found) live[free_slot] <= 1'b1;
      if (cmd.apply) begin
        taken[pick_slot] <= 1'b1;
        if (pick_iv == '0) begin
          live[pick_slot] <= 1'b0;
          gen[pick_slot] <= gen[pick_slot] + 1'b1;
        end
      end
    end
  end

  // One slot a cycle: earliest live expiry, lowest free slot, earliest due timer.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_on <= 1'b0;
      rd_v <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rd_v <= scan_on;
      done_q <= rd_v && (rd_idx == LAST_IDX);
      if (cmd.scan_start) begin
        scan_on <= 1'b1;
      end else if (scan_on && (sidx == LAST_IDX)) begin
        scan_on <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= sidx;
    if (cmd.scan_start) begin
      sidx <= '0;
      any_live <= 1'b0;
      best <= '0;
      free_found <= 1'b0;
      pick_found <= 1'b0;
    end else begin
      if (scan_on) sidx <= sidx + 1'b1;
      if (rd_v) begin
        if (live[rd_idx] && (!any_live || rd_exp < best)) begin
          any_live <= 1'b1;
          best <= rd_exp;
        end
        if (!live[rd_idx] && !free_found) begin
          free_found <= 1'b1;
          free_slot <= rd_idx;
        end
        if (live[rd_idx] && !taken[rd_idx] && (rd_exp <= r_now) &&
            (!pick_found || rd_exp < pick_exp)) begin
          pick_found <= 1'b1;
          pick_slot <= rd_idx;
          pick_exp <= rd_exp;
          pick_iv <= rd_iv;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) bmem[n[tqr_pkg::RES_IW-1:0]] <= {pick_slot, gen[pick_slot], pick_iv != '0};
    if (cmd.emit_rd) b_rd <= bmem[eidx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
      eidx <= '0;
    end else if (cmd.latch) begin
      n <= '0;
      eidx <= '0;
    end else begin
      if (cmd.apply) n <= n + 1'b1;
      if (cmd.emit_out) eidx <= eidx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmd.add_do || cmd.out_single || cmd.emit_out;
    end
  end

  always_ff @(posedge clk) begin
    next_deadline <= best;
    deadline_valid <= any_live;
    was_rearmed <= 1'b0;
    earliest_changed <= 1'b0;
    last <= 1'b1;
    if (cmd.add_do) begin
      if (free_found) begin
        kind <= tqr_pkg::KIND_ADDED;
        handle_slot <= tqr_pkg::SLOT_W'(free_slot);
        handle_generation <= gen[free_slot];
        earliest_changed <= add_early;
        next_deadline <= add_early ? r_exp : best;
        deadline_valid <= 1'b1;
      end else begin
        kind <= tqr_pkg::KIND_FULL;
        handle_slot <= '0;
        handle_generation <= '0;
      end
    end else if (cmd.out_single) begin
      if (r_cmd == tqr_pkg::CMD_CANCEL) begin
        kind <= c_hit ? tqr_pkg::KIND_CANCELLED : tqr_pkg::KIND_NOT_FOUND;
        handle_slot <= r_cs;
        handle_generation <= r_cg;
      end else begin
        kind <= tqr_pkg::KIND_NONE;
        handle_slot <= '0;
        handle_generation <= '0;
      end
    end else if (cmd.emit_out) begin
      kind <= tqr_pkg::KIND_EXPIRED;
      handle_slot <= tqr_pkg::SLOT_W'(b_rd[BW-1 -: IW]);
      handle_generation <= b_rd[tqr_pkg::GEN_W:1];
      was_rearmed <= b_rd[0];
      last <= sts.emit_last;
    end
  end

  assign sts.scan_done = done_q;
  assign sts.is_add = (r_cmd == tqr_pkg::CMD_ADD);
  assign sts.is_cancel = (r_cmd == tqr_pkg::CMD_CANCEL);
  assign sts.pick_ok = pick_found && (n < tqr_pkg::RES_CW'(tqr_pkg::MAX_RES));
  assign sts.any_res = (n != '0);
  assign sts.emit_last = ({1'b0, eidx} == (n - 1'b1));

  `TQR_ASSERT_IMP(a_no_deadline_zero, valid && !deadline_valid, next_deadline == '0, "deadline without timer")
  `TQR_ASSERT_IMP(a_count_bound, 1'b1, n <= tqr_pkg::RES_CW'(tqr_pkg::MAX_RES), "result count overflow")
  `TQR_ASSERT_IMP(a_pick_untaken, cmd.apply, pick_found && !taken[pick_slot], "timer picked twice")
  `TQR_ASSERT_NXT(a_add_live, cmd.add_do && free_found, live[$past(free_slot)], "added slot not live")

endmodule

// ===== hw/rtl/timer_queue_with_rearm_unit.sv =====
// Timer queue with rearm: a table of TIMER_SLOTS timers; expired ones are taken by expiry, then slot.
// An item is taken when start is high and busy is low; it carries command,
// expiry_time and repeat_interval (add), now_time (timeout), cancel_slot and
// cancel_generation (cancel). Results leave one per strobe on valid, with last
// set on the final result of an item; the receiver takes each result in the
// cycle it is shown and cannot stall the block.
// Every pass of the scan unit reads one slot a cycle from the expiry table,
// and the sequencer waits for the pass to finish. An add takes one pass and
// then writes the new timer; a cancel checks the handle, then makes one pass.
// A timeout makes one pass per expired timer that it applies and a final
// pass, then reads and launches the results one by one; at most 32 expired
// timers are emitted per item, and with nothing expired a single KIND_NONE
// result is given.
// One item is in work at a time; busy stays high until its last result is
// launched. Reset clears all slots to free with generation zero and leaves
// the block idle, ready for an item in the next cycle.
// Depends on tqr_pkg, tqr_ctrl and tqr_dp.
module timer_queue_with_rearm_unit #(
  parameter int TIMER_SLOTS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    command,
  input  logic [tqr_pkg::EXP_W-1:0]     expiry_time,
  input  logic [tqr_pkg::IV_W-1:0]      repeat_interval,
  input  logic [tqr_pkg::EXP_W-1:0]     now_time,
  input  logic [tqr_pkg::SLOT_W-1:0]    cancel_slot,
  input  logic [tqr_pkg::GEN_W-1:0]     cancel_generation,
  output logic                          valid,
  output logic [2:0]                    kind,
  output logic [tqr_pkg::SLOT_W-1:0]    handle_slot,
  output logic [tqr_pkg::GEN_W-1:0]     handle_generation,
  output logic                          was_rearmed,
  output logic                          earliest_changed,
  output logic [tqr_pkg::EXP_W-1:0]     next_deadline,
  output logic                          deadline_valid,
  output logic                          last
);

  tqr_pkg::cmd_t cmd;
  tqr_pkg::sts_t sts;

  tqr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  tqr_dp #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .command           (command),
    .expiry_time       (expiry_time),
    .repeat_interval   (repeat_interval),
    .now_time          (now_time),
    .cancel_slot       (cancel_slot),
    .cancel_generation (cancel_generation),
    .valid             (valid),
    .kind              (kind),
    .handle_slot       (handle_slot),
    .handle_generation (handle_generation),
    .was_rearmed       (was_rearmed),
    .earliest_changed  (earliest_changed),
    .next_deadline     (next_deadline),
    .deadline_valid    (deadline_valid),
    .last              (last)
  );

endmodule
